/* rtl/core/erd_pkg.sv */
// ----------------------------------------------------------------------------
// erd_pkg - shared types and codes for the edge ring deque
// Transfer payloads, stored edge layout, action and status codes, sequencer
// states.
// ----------------------------------------------------------------------------
`default_nettype none

package erd_pkg;

  // ring capacity; position and count widths follow from it
  localparam int DEPTH   = 64;
  localparam int POS_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // action codes
  localparam logic [3:0] ACT_PUSH_FRONT = 4'd0;
  localparam logic [3:0] ACT_PUSH_BACK  = 4'd1;
  localparam logic [3:0] ACT_POP_FRONT  = 4'd2;
  localparam logic [3:0] ACT_POP_BACK   = 4'd3;
  localparam logic [3:0] ACT_PEEK_FRONT = 4'd4;
  localparam logic [3:0] ACT_PEEK_BACK  = 4'd5;
  localparam logic [3:0] ACT_READ_AT    = 4'd6;
  localparam logic [3:0] ACT_FIND       = 4'd7;
  localparam logic [3:0] ACT_SORT_DESC  = 4'd8;
  localparam logic [3:0] ACT_SORT_ASC   = 4'd9;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  // one stored edge: src 31..24, dst 23..16, weight 15..0
  typedef struct packed {
    logic [7:0]         src;
    logic [7:0]         dst;
    logic signed [15:0] weight;
  } edge_t;

  typedef struct packed {
    logic [3:0]         action;
    logic [7:0]         src_node;
    logic [7:0]         dst_node;
    logic signed [15:0] edge_weight;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [COUNT_W-1:0] count;
    logic [7:0]         out_src;
    logic [7:0]         out_dst;
    logic signed [15:0] out_weight;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_FIND,
    S_SORT_LOAD,
    S_SORT_FIRST,
    S_SORT_STEP,
    S_SORT_TAIL,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/erd_store.sv */
// ----------------------------------------------------------------------------
// erd_store - edge storage array
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module erd_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  erd_pkg::edge_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output erd_pkg::edge_t  rd_data
);
  import erd_pkg::*;

  edge_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/edge_ring_deque.sv */
// ----------------------------------------------------------------------------
// edge_ring_deque - ring deque of weighted graph edges
// Push/pop at both ends, peek, indexed read, exact search and stable sort by
// weight, run by a small sequencer over one storage array.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req (req_valid / req_stall), one result per request
//   leaves on rsp (rsp_valid / rsp_stall). req_stall is high while a request
//   is being worked on; a new request is taken as soon as the sequencer is
//   idle again, even when the previous result still waits in the output
//   register.
//   Push, pop, unused actions, error cases and sorts of fewer than 2
//   entries go from dispatch straight to the response state; peek and
//   read_at make one read, find stops at the first hit. Run time is set
//   by the single read and single write port of the store: find reads one
//   entry a cycle, sort runs bubble passes with one compare and one write
//   per cycle plus, per pass, S_SORT_FIRST to load the first entry and
//   S_SORT_TAIL to write the tail. The result is loaded into the output
//   register from the response state.
//   Reset (rst, synchronous) empties the deque and drops a pending result;
//   the store contents are not cleared. While rsp_valid and rsp_stall are
//   both high the result holds and the sequencer waits in S_RESP.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_ring_deque (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  erd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output erd_pkg::rsp_t rsp
);
  import erd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  // logical position to physical slot, sum stays below twice the depth
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] logical);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(logical);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  state_t        state, state_next;
  req_t          req_q, req_q_next;
  logic [PW-1:0] front_ptr, front_ptr_next;
  logic [CW-1:0] fill_count, fill_count_next;
  logic [CW-1:0] walk, walk_next;
  logic [CW-1:0] pass_i, pass_i_next;
  logic          pend, pend_next;
  edge_t         carry, carry_next;
  logic [1:0]    res_status, res_status_next;
  logic          res_found, res_found_next;
  edge_t         res_edge, res_edge_next;

  // store port controls
  logic          wr_en, rd_en;
  logic [PW-1:0] wr_base, wr_addr, rd_addr;
  logic [CW-1:0] wr_log, rd_log;
  edge_t         wr_data, rd_data;

  // shared conditions
  edge_t         req_edge;
  logic          empty, full, match, swap, step_last, out_of_range, load_rsp;
  logic [PW-1:0] prev_front, next_front;
  logic [CW-1:0] peek_log;
  logic [XW-1:0] pos_ext;

  assign req_stall = (state != S_IDLE);
  assign req_edge  = '{src: req_q.src_node, dst: req_q.dst_node,
                       weight: req_q.edge_weight};
  assign empty     = (fill_count == '0);
  assign full      = (fill_count == CW'(DEPTH));
  assign match     = pend && (rd_data == req_edge);
  assign step_last = ((walk + CW'(1)) == pass_i);
  assign load_rsp  = (state == S_RESP) && (!rsp_valid || !rsp_stall);

  assign prev_front = (front_ptr == '0) ? PW'(DEPTH - 1) : front_ptr - PW'(1);
  assign next_front = (front_ptr == PW'(DEPTH - 1)) ? '0 : front_ptr + PW'(1);

  // weight comparator for sort
  always_comb begin
    if (req_q.action == ACT_SORT_ASC) begin
      swap = (rd_data.weight < carry.weight);
    end else begin
      swap = (rd_data.weight > carry.weight);
    end
  end

  // logical position for peek and read_at
  assign pos_ext      = XW'(req_q.position);
  assign out_of_range = (req_q.action == ACT_READ_AT) && (pos_ext >= XW'(fill_count));
  always_comb begin
    case (req_q.action)
      ACT_PEEK_FRONT: peek_log = '0;
      ACT_PEEK_BACK:  peek_log = fill_count - CW'(1);
      default:        peek_log = pos_ext[CW-1:0];
    endcase
  end

  // address units
  assign wr_addr = slot_of(wr_base, wr_log);
  assign rd_addr = slot_of(front_ptr, rd_log);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (req_q.action inside {ACT_PEEK_FRONT, ACT_PEEK_BACK, ACT_READ_AT}) begin
          state_next = (empty || out_of_range) ? S_RESP : S_READ;
        end else if (req_q.action == ACT_FIND) begin
          state_next = empty ? S_RESP : S_FIND;
        end else if (req_q.action inside {ACT_SORT_DESC, ACT_SORT_ASC}) begin
          state_next = (fill_count < CW'(2)) ? S_RESP : S_SORT_LOAD;
        end else begin
          state_next = S_RESP;
        end
      end
      S_READ:       state_next = S_RESP;
      S_FIND: begin
        if (pend && (match || walk == fill_count)) state_next = S_RESP;
      end
      S_SORT_LOAD:  state_next = S_SORT_FIRST;
      S_SORT_FIRST: state_next = S_SORT_STEP;
      S_SORT_STEP: begin
        if (step_last) state_next = S_SORT_TAIL;
      end
      S_SORT_TAIL: begin
        state_next = (pass_i == CW'(1)) ? S_RESP : S_SORT_FIRST;
      end
      S_RESP: begin
        if (load_rsp) state_next = S_IDLE;
      end
      default:      state_next = S_IDLE;
    endcase
  end

  // datapath controls and register next values
  always_comb begin
    req_q_next      = req_q;
    front_ptr_next  = front_ptr;
    fill_count_next = fill_count;
    walk_next       = walk;
    pass_i_next     = pass_i;
    pend_next       = pend;
    carry_next      = carry;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_edge_next   = res_edge;
    wr_en           = 1'b0;
    wr_base         = front_ptr;
    wr_log          = '0;
    wr_data         = carry;
    rd_en           = 1'b0;
    rd_log          = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_q_next      = req;
          res_status_next = STAT_OK;
          res_found_next  = 1'b0;
          res_edge_next   = '0;
        end
      end
      S_DISPATCH: begin
        wr_data = req_edge;
        case (req_q.action)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (full) begin
              res_status_next = STAT_FULL;
            end else if (empty) begin
              front_ptr_next  = '0;
              wr_en           = 1'b1;
              wr_base         = '0;
              fill_count_next = CW'(1);
            end else if (req_q.action == ACT_PUSH_FRONT) begin
              front_ptr_next  = prev_front;
              wr_en           = 1'b1;
              wr_base         = prev_front;
              fill_count_next = fill_count + CW'(1);
            end else begin
              wr_en           = 1'b1;
              wr_log          = fill_count;
              fill_count_next = fill_count + CW'(1);
            end
          end
          ACT_POP_FRONT, ACT_POP_BACK: begin
            if (empty) begin
              res_status_next = STAT_EMPTY;
            end else if (fill_count == CW'(1)) begin
              fill_count_next = '0;
              front_ptr_next  = '0;
            end else begin
              fill_count_next = fill_count - CW'(1);
              if (req_q.action == ACT_POP_FRONT) front_ptr_next = next_front;
            end
          end
          ACT_PEEK_FRONT, ACT_PEEK_BACK, ACT_READ_AT: begin
            if (empty) begin
              res_status_next = STAT_EMPTY;
            end else if (out_of_range) begin
              res_status_next = STAT_RANGE;
            end else begin
              rd_en  = 1'b1;
              rd_log = peek_log;
            end
          end
          ACT_FIND: begin
            if (empty) res_status_next = STAT_EMPTY;
            walk_next = '0;
            pend_next = 1'b0;
          end
          ACT_SORT_DESC, ACT_SORT_ASC: begin
            pass_i_next = fill_count - CW'(1);
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        res_edge_next = rd_data;
      end
      // one read issued per cycle, previous entry compared
      S_FIND: begin
        if (match) res_found_next = 1'b1;
        pend_next = (walk < fill_count);
        if (walk < fill_count) begin
          rd_en     = 1'b1;
          rd_log    = walk;
          walk_next = walk + CW'(1);
        end
      end
      S_SORT_LOAD: begin
        rd_en  = 1'b1;
        rd_log = '0;
      end
      S_SORT_FIRST: begin
        carry_next = rd_data;
        rd_en      = 1'b1;
        rd_log     = CW'(1);
        walk_next  = '0;
      end
      // carry holds the entry bubbling up; settle position walk
      S_SORT_STEP: begin
        wr_en      = 1'b1;
        wr_log     = walk;
        wr_data    = swap ? rd_data : carry;
        carry_next = swap ? carry : rd_data;
        if (!step_last) begin
          rd_en     = 1'b1;
          rd_log    = walk + CW'(2);
          walk_next = walk + CW'(1);
        end
      end
      S_SORT_TAIL: begin
        wr_en       = 1'b1;
        wr_log      = pass_i;
        wr_data     = carry;
        pass_i_next = pass_i - CW'(1);
        if (pass_i != CW'(1)) begin
          rd_en  = 1'b1;
          rd_log = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front_ptr  <= '0;
      fill_count <= '0;
      pend       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      front_ptr  <= front_ptr_next;
      fill_count <= fill_count_next;
      pend       <= pend_next;
      rsp_valid  <= load_rsp || (rsp_valid && rsp_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_q      <= req_q_next;
    walk       <= walk_next;
    pass_i     <= pass_i_next;
    carry      <= carry_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_edge   <= res_edge_next;
    if (load_rsp) begin
      rsp <= '{status: res_status, found: res_found, count: COUNT_W'(fill_count),
               out_src: res_edge.src, out_dst: res_edge.dst,
               out_weight: res_edge.weight};
    end
  end

  erd_store #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front_ptr <= PW'(DEPTH - 1))
    else $error("front pointer outside ring");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (fill_count == '0) |-> (front_ptr == '0))
    else $error("empty deque with nonzero front pointer");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESP) |-> !wr_en)
    else $error("store written outside a work state");

endmodule

`default_nettype wire

/* tb/edge_ring_deque_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_ring_deque_tb - self-checking bench for the edge ring deque
// Directed corner requests first (empty and single-entry cases, wrap of the
// front pointer, out-of-range reads, find hit and miss, both sorts, unused
// actions), then random requests that fill the ring to capacity and drain it
// again, under four idle/stall phases. A scoreboard class keeps its own copy
// of the ring, predicts every result and checks response transfers in order.
// ----------------------------------------------------------------------------
module edge_ring_deque_tb;
  import erd_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int MAX_PRINTS   = 60;

  // Ring contents as the block should hold them, plus the results still owed
  class deque_ledger;
    edge_t       slots [DEPTH];
    int unsigned head;
    int unsigned fill;
    rsp_t        awaited [$];
    int          errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function edge_t slot_at(int unsigned logical);
      return slots[(head + logical) % DEPTH];
    endfunction

    // bubble passes in ring order; strict compare keeps equal weights in order
    function void sort_by_weight(bit ascending);
      int unsigned i;
      int unsigned j;
      int unsigned a;
      int unsigned b;
      edge_t       t;
      bit          swap;
      if (fill < 2) return;
      for (i = fill - 1; i > 0; i--) begin
        for (j = 0; j < i; j++) begin
          a = (head + j) % DEPTH;
          b = (head + j + 1) % DEPTH;
          if (ascending) swap = ($signed(slots[b].weight) < $signed(slots[a].weight));
          else swap = ($signed(slots[b].weight) > $signed(slots[a].weight));
          if (swap) begin
            t        = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
          end
        end
      end
    endfunction

    // apply one request to the ring and return the result it should give
    function rsp_t next_result(req_t r);
      rsp_t        o;
      edge_t       e;
      int unsigned lp;
      o = '0;
      e = '{src: r.src_node, dst: r.dst_node, weight: r.edge_weight};
      case (r.action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            o.status = STAT_FULL;
          end else if (fill == 0) begin
            head     = 0;
            slots[0] = e;
            fill     = 1;
          end else if (r.action == ACT_PUSH_FRONT) begin
            head        = (head + DEPTH - 1) % DEPTH;
            slots[head] = e;
            fill++;
          end else begin
            slots[(head + fill) % DEPTH] = e;
            fill++;
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (fill == 0) begin
            o.status = STAT_EMPTY;
          end else if (fill == 1) begin
            fill = 0;
            head = 0;
          end else begin
            fill--;
            if (r.action == ACT_POP_FRONT) head = (head + 1) % DEPTH;
          end
        end
        ACT_PEEK_FRONT, ACT_PEEK_BACK, ACT_READ_AT: begin
          if (fill == 0) begin
            o.status = STAT_EMPTY;
          end else begin
            if (r.action == ACT_PEEK_FRONT) lp = 0;
            else if (r.action == ACT_PEEK_BACK) lp = fill - 1;
            else lp = r.position;
            if (lp >= fill) begin
              o.status = STAT_RANGE;
            end else begin
              e            = slot_at(lp);
              o.out_src    = e.src;
              o.out_dst    = e.dst;
              o.out_weight = e.weight;
            end
          end
        end
        ACT_FIND: begin
          if (fill == 0) o.status = STAT_EMPTY;
          else for (int unsigned i = 0; i < fill; i++) if (slot_at(i) == e) o.found = 1'b1;
        end
        ACT_SORT_DESC: sort_by_weight(1'b0);
        ACT_SORT_ASC:  sort_by_weight(1'b1);
        default: ;
      endcase
      o.count = COUNT_W'(fill);
      return o;
    endfunction

    function void note_request(req_t r);
      awaited.push_back(next_result(r));
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result st=%0d cnt=%0d", got.status, got.count));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.count !== want.count || got.out_src !== want.out_src ||
          got.out_dst !== want.out_dst || got.out_weight !== want.out_weight)
        report($sformatf({"got st=%0d fnd=%0d cnt=%0d edge=%0d/%0d/%0d, ",
                          "want st=%0d fnd=%0d cnt=%0d edge=%0d/%0d/%0d"},
                         got.status, got.found, got.count, got.out_src, got.out_dst,
                         got.out_weight, want.status, want.found, want.count,
                         want.out_src, want.out_dst, want.out_weight));
    endtask

    task finish_check();
      if (awaited.size() != 0)
        report($sformatf("%0d results never arrived", awaited.size()));
    endtask
  endclass

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req       = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    fill_mode     = 1;  // 0 balanced, 1 filling, 2 draining
  deque_ledger ledger;

  edge_ring_deque DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // one request transfer, with optional idle cycles ahead of it
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    ledger.note_request(r);
  endtask

  function automatic req_t mk(logic [3:0] act, logic [7:0] s, logic [7:0] d,
                              logic signed [15:0] w, logic [POS_W-1:0] p);
    req_t r;
    r.action      = act;
    r.src_node    = s;
    r.dst_node    = d;
    r.edge_weight = w;
    r.position    = p;
    return r;
  endfunction

  // extremes, a narrow band for duplicate weights, or anything
  function automatic logic signed [15:0] random_weight();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case (pick % 4)
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'shffff;
        default: return 16'sh0000;
      endcase
    end
    if (pick < 45) return 16'(int'($urandom_range(4)) - 2);
    return 16'($urandom);
  endfunction

  function automatic req_t random_request();
    req_t  r;
    edge_t e;
    int    pick;
    int    push_cut;
    r.src_node    = 8'($urandom_range(255));
    r.dst_node    = 8'($urandom_range(255));
    r.edge_weight = random_weight();
    r.position    = POS_W'($urandom_range(63));
    push_cut = (fill_mode == 1) ? 62 : (fill_mode == 2) ? 10 : 38;
    pick     = $urandom_range(99);
    if (pick < push_cut) begin
      r.action = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    end else if (pick < 70) begin
      r.action = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    end else if (pick < 77) begin
      r.action = $urandom_range(1) ? ACT_PEEK_BACK : ACT_PEEK_FRONT;
    end else if (pick < 86) begin
      r.action = ACT_READ_AT;
      if (ledger.fill != 0 && $urandom_range(3) != 0)
        r.position = POS_W'($urandom_range(ledger.fill - 1));
    end else if (pick < 94) begin
      // mostly look for an edge that is stored, sometimes one bit off
      r.action = ACT_FIND;
      if (ledger.fill != 0 && $urandom_range(4) < 3) begin
        e             = ledger.slot_at($urandom_range(ledger.fill - 1));
        r.src_node    = e.src;
        r.dst_node    = e.dst;
        r.edge_weight = e.weight;
        if ($urandom_range(4) == 0)
          r.edge_weight = e.weight ^ 16'(1 << $urandom_range(15));
      end
    end else if (pick < 97) begin
      r.action = $urandom_range(1) ? ACT_SORT_ASC : ACT_SORT_DESC;
    end else begin
      r.action = 4'($urandom_range(15, 10));
    end
    return r;
  endfunction

  task automatic directed_part();
    send_req(mk(ACT_POP_FRONT,  8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_POP_BACK,   8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_PEEK_FRONT, 8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_PEEK_BACK,  8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_READ_AT,    8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_FIND,       8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_SORT_DESC,  8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_SORT_ASC,   8'h00, 8'h00, 16'sh0000, 6'd0));
    // single entry: sort is a no-op, popping it resets the front
    send_req(mk(ACT_PUSH_BACK,  8'hff, 8'hff, 16'sh7fff, 6'd63));
    send_req(mk(ACT_SORT_ASC,   8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_POP_BACK,   8'h00, 8'h00, 16'sh0000, 6'd0));
    // push_front on empty lands in slot 0, the next one wraps the front
    send_req(mk(ACT_PUSH_FRONT, 8'h00, 8'h00, 16'sh8000, 6'd0));
    send_req(mk(ACT_PUSH_FRONT, 8'haa, 8'h55, 16'sh5555, 6'd0));
    send_req(mk(ACT_PUSH_BACK,  8'h55, 8'haa, 16'shaaaa, 6'd0));
    send_req(mk(ACT_PEEK_FRONT, 8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_PEEK_BACK,  8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_READ_AT,    8'h00, 8'h00, 16'sh0000, 6'd1));
    send_req(mk(ACT_READ_AT,    8'h00, 8'h00, 16'sh0000, 6'd63));
    send_req(mk(ACT_FIND,       8'h00, 8'h00, 16'sh8000, 6'd0));
    send_req(mk(ACT_FIND,       8'h00, 8'h01, 16'sh8000, 6'd0));
    send_req(mk(ACT_SORT_DESC,  8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_SORT_ASC,   8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(4'd10,          8'hff, 8'hff, 16'shffff, 6'd63));
    send_req(mk(4'd15,          8'h00, 8'h00, 16'sh0000, 6'd0));
    send_req(mk(ACT_POP_FRONT,  8'h00, 8'h00, 16'sh0000, 6'd0));
  endtask

  // response side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) ledger.check_result(rsp);
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    ledger = new();
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    directed_part();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 50; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      repeat (RANDOM_ITEMS / 4) begin
        send_req(random_request());
        // hold at full for a few pushes before draining, and vice versa
        if (ledger.fill == DEPTH && $urandom_range(7) == 0) fill_mode = 2;
        else if (ledger.fill == 0 && $urandom_range(3) == 0) fill_mode = 1;
        else if ($urandom_range(59) == 0) fill_mode = $urandom_range(2);
      end
    end
    req_valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    ledger.finish_check();
    if (ledger.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #(64'd50_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
